// ----- src/ngdp_pkg.sv -----
package ngdp_pkg;

  localparam int VALUE_W        = 31;
  localparam int DATA_W         = 32;
  localparam int DIG_W          = 4;
  localparam int ACC_W          = VALUE_W + 4;
  localparam int MAX_DIGITS_DEF = 10;

  localparam logic [VALUE_W-1:0] RESULT_LIMIT = {VALUE_W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_PIVOT,
    S_CHECK,
    S_UP,
    S_JOIN,
    S_SUFFIX,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    DOP_HOLD,
    DOP_CLEAR,
    DOP_DABBLE,
    DOP_ROT_DN,
    DOP_ROT_UP
  } dig_op_t;

  typedef struct packed {
    dig_op_t op;
    logic    bin_bit;
  } dig_ctl_t;

endpackage

// ----- src/next_greater_digit_permutation.sv -----
// Next greater digit permutation: takes a 31-bit value on the in_ stream and
// returns the smallest larger value built from the same decimal digits on the
// out_ stream, with a found flag that is low (and the value zero) when the
// input has fewer than two digits, its digits never rise from left to right,
// it has more than MAX_DIGITS digits, or the permutation exceeds 2^31-1.
// One item is in flight at a time. After the accepting edge an item passes
// through binary to BCD conversion (one input bit per cycle through the digit
// shift register), the pivot scan, a check state, the high-digit accumulate
// and swap search, a join state, the reversed suffix (k digits, k = pivot
// position) and the load of the output register, which raises out_tvalid.
// When no permutation exists, the check state goes straight to that load.
// The single digit register is walked one digit per cycle during the scans.
// in_tready is high only while the block is idle. A finished result waits in
// the output register while the next item is accepted and converted; if the
// receiver stalls, the block holds in its final state until the output
// register frees up. Reset (rst_n low, synchronous) empties the output
// register and returns the block to idle.
module next_greater_digit_permutation #(
  parameter int MAX_DIGITS = ngdp_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ngdp_pkg::DATA_W-1:0] in_tdata,   // [30:0] value, [31] zero
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ngdp_pkg::DATA_W-1:0] out_tdata   // [0] found, [31:1] next_value
);
  import ngdp_pkg::*;

  localparam int IW = $clog2(MAX_DIGITS);
  localparam int BW = $clog2(VALUE_W);
  localparam logic [IW-1:0] LAST_POS = IW'(MAX_DIGITS - 1);
  localparam logic [BW-1:0] LAST_BIT = BW'(VALUE_W - 1);

  state_t state_r, state_nxt;
  dig_ctl_t dig_ctl;

  logic [VALUE_W-1:0] bin_r;
  logic [BW-1:0]      bcnt_r;
  logic [IW-1:0]      pos_r;
  logic [DIG_W-1:0]   prev_r;
  logic [IW-1:0]      k_r;
  logic [DIG_W-1:0]   piv_r;
  logic               kfound_r;
  logic [IW-1:0]      topnz_r;
  logic [IW-1:0]      j_r;
  logic [DIG_W-1:0]   jv_r;
  logic [VALUE_W-1:0] acc_r;
  logic               aovf_r;
  logic               res_ok_r;

  logic               out_valid_r;
  logic               out_found_r;
  logic [VALUE_W-1:0] out_value_r;

  logic [DIG_W-1:0]   lo_digit;
  logic [DIG_W-1:0]   hi_digit;
  logic               too_long;

  logic               h_en;
  logic [DIG_W-1:0]   h_dig;
  logic [ACC_W-1:0]   h_wide;
  logic               in_acc;
  logic               out_free;
  logic               res_found;

  ngdp_digit_reg #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_digits (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dig_ctl),
    .lo_digit (lo_digit),
    .hi_digit (hi_digit),
    .too_long (too_long)
  );

  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign res_found = res_ok_r && !aovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state, digit register command and input handshake
  always_comb begin
    state_nxt       = state_r;
    dig_ctl.op      = DOP_HOLD;
    dig_ctl.bin_bit = bin_r[VALUE_W-1];
    in_tready       = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          dig_ctl.op = DOP_CLEAR;
          state_nxt  = S_CONV;
        end
      end
      S_CONV: begin
        dig_ctl.op = DOP_DABBLE;
        if (bcnt_r == LAST_BIT) state_nxt = S_PIVOT;
      end
      S_PIVOT: begin
        dig_ctl.op = DOP_ROT_DN;
        if (pos_r == LAST_POS) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (too_long || !kfound_r || k_r > topnz_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        dig_ctl.op = DOP_ROT_UP;
        if (pos_r == '0) state_nxt = S_JOIN;
      end
      S_JOIN: begin
        state_nxt = S_SUFFIX;
      end
      S_SUFFIX: begin
        dig_ctl.op = DOP_ROT_DN;
        if (pos_r == k_r - 1'b1) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // one Horner step: acc * 10 + digit, with a sticky overflow past 2^31-1
  always_comb begin
    h_en  = 1'b0;
    h_dig = '0;
    case (state_r)
      S_UP: begin
        h_en  = pos_r > k_r;
        h_dig = hi_digit;
      end
      S_JOIN: begin
        h_en  = 1'b1;
        h_dig = jv_r;
      end
      S_SUFFIX: begin
        h_en  = 1'b1;
        h_dig = (pos_r == j_r) ? piv_r : lo_digit;
      end
      default: begin
      end
    endcase
    h_wide = ACC_W'({acc_r, 3'b000}) + ACC_W'({acc_r, 1'b0}) + ACC_W'(h_dig);
  end

  // datapath: scan, swap search and accumulate
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        bin_r  <= in_tdata[VALUE_W-1:0];
        bcnt_r <= '0;
      end
      S_CONV: begin
        bin_r    <= {bin_r[VALUE_W-2:0], 1'b0};
        bcnt_r   <= bcnt_r + 1'b1;
        pos_r    <= '0;
        kfound_r <= 1'b0;
        topnz_r  <= '0;
        prev_r   <= '0;
      end
      S_PIVOT: begin
        // lowest position whose digit is below its right neighbor
        if (lo_digit != '0) topnz_r <= pos_r;
        if (pos_r != '0 && !kfound_r && lo_digit < prev_r) begin
          kfound_r <= 1'b1;
          k_r      <= pos_r;
          piv_r    <= lo_digit;
        end
        prev_r <= lo_digit;
        pos_r  <= pos_r + 1'b1;
      end
      S_CHECK: begin
        res_ok_r <= !(too_long || !kfound_r || k_r > topnz_r);
        pos_r    <= LAST_POS;
        acc_r    <= '0;
        aovf_r   <= 1'b0;
        j_r      <= '0;
        jv_r     <= '0;
      end
      S_UP: begin
        // the last larger digit seen below the pivot is the rightmost one
        if (pos_r < k_r && hi_digit > piv_r) begin
          j_r  <= pos_r;
          jv_r <= hi_digit;
        end
        pos_r <= pos_r - 1'b1;
      end
      S_JOIN: begin
        pos_r <= '0;
      end
      S_SUFFIX: begin
        pos_r <= pos_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (h_en) begin
      acc_r <= h_wide[VALUE_W-1:0];
      if (h_wide > ACC_W'(RESULT_LIMIT)) aovf_r <= 1'b1;
    end
  end

  // output register: holds a result while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_found_r <= res_found;
      out_value_r <= res_found ? acc_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_value_r, out_found_r};

endmodule

// ----- src/ngdp_digit_reg.sv -----
module ngdp_digit_reg #(
  parameter int MAX_DIGITS = ngdp_pkg::MAX_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ngdp_pkg::dig_ctl_t         ctl,
  output logic [ngdp_pkg::DIG_W-1:0] lo_digit,
  output logic [ngdp_pkg::DIG_W-1:0] hi_digit,
  output logic                       too_long
);
  import ngdp_pkg::*;

  logic [DIG_W-1:0] dig_r [MAX_DIGITS];
  logic [DIG_W-1:0] adj   [MAX_DIGITS];
  logic             too_long_r;

  // add-3 correction per digit lane before the doubling shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (dig_r[i] >= DIG_W'(5)) ? dig_r[i] + DIG_W'(3) : dig_r[i];
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      DOP_CLEAR: begin
        for (int i = 0; i < MAX_DIGITS; i++) dig_r[i] <= '0;
      end
      DOP_DABBLE: begin
        dig_r[0] <= {adj[0][DIG_W-2:0], ctl.bin_bit};
        for (int i = 1; i < MAX_DIGITS; i++) begin
          dig_r[i] <= {adj[i][DIG_W-2:0], adj[i-1][DIG_W-1]};
        end
      end
      DOP_ROT_DN: begin
        for (int i = 0; i < MAX_DIGITS - 1; i++) dig_r[i] <= dig_r[i+1];
        dig_r[MAX_DIGITS-1] <= dig_r[0];
      end
      DOP_ROT_UP: begin
        for (int i = 1; i < MAX_DIGITS; i++) dig_r[i] <= dig_r[i-1];
        dig_r[0] <= dig_r[MAX_DIGITS-1];
      end
      default: begin
      end
    endcase
  end

  // carry out of the top digit means the value needs more digit slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      too_long_r <= 1'b0;
    end else if (ctl.op == DOP_CLEAR) begin
      too_long_r <= 1'b0;
    end else if (ctl.op == DOP_DABBLE && adj[MAX_DIGITS-1][DIG_W-1]) begin
      too_long_r <= 1'b1;
    end
  end

  assign lo_digit = dig_r[0];
  assign hi_digit = dig_r[MAX_DIGITS-1];
  assign too_long = too_long_r;

endmodule

// ----- tb/tb_next_greater_digit_permutation.sv -----
module tb_next_greater_digit_permutation;
  timeunit 1ns;
  timeprecision 1ps;

  import ngdp_pkg::*;

  localparam int         DIGITS      = MAX_DIGITS_DEF;
  localparam int         CYCLE_LIMIT = 500000;
  localparam int         HOLD_CYCLES = 400;
  localparam longint     VALUE_MAX   = 64'd2147483647;

  // Same layout as out_tdata: found in bit 0, next_value above it
  typedef struct packed {
    logic [VALUE_W-1:0] next_value;
    logic               found;
  } perm_result_t;

  // Predicts the next digit permutation of each accepted value and matches
  // the block's results against it in order.
  class perm_scoreboard;
    perm_result_t pending_perms[$];
    int           errors;
    int           results_seen;
    int           found_seen;
    int           reports;

    function new();
      errors       = 0;
      results_seen = 0;
      found_seen   = 0;
      reports      = 0;
    endfunction

    // Next larger value made of the same decimal digits; found stays low
    // for single digits, digits that never rise, too many digits or overflow.
    function perm_result_t next_perm(logic [VALUE_W-1:0] value);
      logic [3:0]      dg[DIGITS];
      logic [3:0]      t;
      longint unsigned rest;
      longint unsigned acc;
      int              n;
      int              p;
      int              s;
      int              lo;
      int              hi;
      perm_result_t    res;
      res  = '0;
      rest = value;
      n    = 0;
      if (rest < 10) return res;
      while (rest != 0) begin
        if (n >= DIGITS) return res;
        dg[n] = 4'(rest % 10);
        rest  = rest / 10;
        n++;
      end
      // pivot: lowest position whose digit is below its lower neighbor
      for (p = 1; p < n; p++) begin
        if (dg[p] < dg[p-1]) break;
      end
      if (p >= n) return res;
      for (s = 0; s < p; s++) begin
        if (dg[s] > dg[p]) break;
      end
      t     = dg[s];
      dg[s] = dg[p];
      dg[p] = t;
      // put the tail below the pivot in ascending order
      lo = 0;
      hi = p - 1;
      while (lo < hi) begin
        t      = dg[lo];
        dg[lo] = dg[hi];
        dg[hi] = t;
        lo++;
        hi--;
      end
      acc = 0;
      for (int i = n - 1; i >= 0; i--) acc = acc * 10 + dg[i];
      if (acc > RESULT_LIMIT) return res;
      res.found      = 1'b1;
      res.next_value = acc[VALUE_W-1:0];
      return res;
    endfunction

    function void note_value(logic [VALUE_W-1:0] value);
      pending_perms.push_back(next_perm(value));
    endfunction

    function void check_result(logic [DATA_W-1:0] word);
      perm_result_t got;
      perm_result_t want;
      got = word;
      results_seen++;
      if (pending_perms.size() == 0) begin
        errors++;
        if (reports++ < 40)
          $display("%0t: result with nothing expected: found=%0d next_value=%0d",
                   $realtime, got.found, got.next_value);
        return;
      end
      want = pending_perms.pop_front();
      if (want.found) found_seen++;
      if (got.found !== want.found) begin
        errors++;
        if (reports++ < 40)
          $display("%0t: found mismatch: expected %0d, actual %0d",
                   $realtime, want.found, got.found);
      end
      if (got.next_value !== want.next_value) begin
        errors++;
        if (reports++ < 40)
          $display("%0t: next_value mismatch: expected %0d, actual %0d",
                   $realtime, want.next_value, got.next_value);
      end
    endfunction

    function int outstanding();
      return pending_perms.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;    // [30:0] value, [31] zero
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;   // [0] found, [31:1] next_value

  perm_scoreboard sb;
  int             cycles = 0;
  bit             rx_steady;
  int             rx_hold_req = 0;
  int             rx_hold_seen = 0;
  int             rx_hold_left = 0;

  next_greater_digit_permutation u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops a result
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycles, sb.outstanding());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Note each item the block takes and check each item it hands out
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_value(in_tdata[VALUE_W-1:0]);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Receiver: random backpressure, a steady mode with none, and a long
  // hold-off counted here once the main sequence requests it.
  always @(negedge clk) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else if (rx_steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 17);
    end
  end

  // Offer one item, optionally after a random gap, and hold it until taken;
  // return on the falling edge after the accepting edge.
  task automatic send_item(input logic [DATA_W-1:0] word, input bit may_idle);
    if (may_idle && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 70)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Always wait for a falling edge before checking, so valid is never dropped and raised
  // in the same time step.
  task automatic wait_drained();
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  // Random values, shaped to hit pivots, no-pivot runs, repeated digits and
  // results near the 31-bit limit; bit 31 is set now and then.
  function automatic logic [DATA_W-1:0] pick_value();
    logic [3:0]      dg[10];
    logic [3:0]      t;
    longint unsigned acc;
    int              kind;
    int              ndig;
    int              top;
    int              a;
    int              b;
    kind = $urandom_range(99);
    do begin
      acc  = 0;
      ndig = $urandom_range(2, 10);
      top  = 9;
      if (kind < 30) begin
        acc = $urandom & 32'h7FFF_FFFF;
      end else if (kind < 88) begin
        for (int i = 0; i < ndig; i++) begin
          if (kind < 55) begin
            dg[i] = 4'($urandom_range(0, 9));
          end else if (kind < 70) begin
            dg[i] = 4'($urandom_range(0, 2));
          end else begin
            dg[i] = 4'($urandom_range(0, top));
            top   = dg[i];
          end
        end
        // nudge a falling run so the pivot lands somewhere random
        if (kind >= 70 && $urandom_range(1)) begin
          a         = $urandom_range(0, ndig - 2);
          t         = dg[a];
          dg[a]     = dg[a+1];
          dg[a+1]   = t;
        end
        for (int i = 0; i < ndig; i++) acc = acc * 10 + dg[i];
      end else begin
        // shuffle the digits of the largest value a little
        dg = '{4'd2, 4'd1, 4'd4, 4'd7, 4'd4, 4'd8, 4'd3, 4'd6, 4'd4, 4'd7};
        repeat ($urandom_range(1, 2)) begin
          a     = $urandom_range(0, 9);
          b     = $urandom_range(0, 9);
          t     = dg[a];
          dg[a] = dg[b];
          dg[b] = t;
        end
        for (int i = 0; i < 10; i++) acc = acc * 10 + dg[i];
      end
    end while (acc > VALUE_MAX);
    return {($urandom_range(15) == 0), acc[VALUE_W-1:0]};
  endfunction

  logic [DATA_W-1:0] directed_values[] = '{
    32'd0,                      // single digit, all bits low
    32'd9,                      // largest single digit
    32'd10,                     // two digits, no pivot
    32'd12,
    32'd21,
    32'd115,
    32'd1000,                   // trailing zeros, no pivot
    32'd4321,                   // falling digits
    32'd1234,
    32'd230241,
    32'd1111111111,             // all digits equal
    32'd999999999,
    32'd1000000000,
    32'd1023456789,
    32'd1234567890,
    32'd2147483476,             // result lands exactly on the limit
    32'd2147483646,             // result just above the limit
    32'd1999999999,             // result far above the limit
    32'h7FFF_FFFF,              // all value bits high, overflows
    32'h2AAA_AAAA,
    32'h5555_5555,
    {1'b1, 31'd1234},           // bit 31 set, must be ignored
    {1'b1, 31'd5}
  };

  initial begin
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    rst_n        = 1'b0;
    rx_steady    = 1'b0;
    sb           = new();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corner values first
    foreach (directed_values[i]) send_item(directed_values[i], 1'b1);

    // random traffic with random gaps on both sides
    repeat (200) send_item(pick_value(), 1'b1);

    // back to back with no idling on either side
    rx_steady = 1'b1;
    repeat (80) send_item(pick_value(), 1'b0);
    rx_steady = 1'b0;

    // long receiver hold-off while the sender keeps pushing: fills the
    // output register and stalls the input
    rx_hold_req++;
    repeat (12) send_item(pick_value(), 1'b0);

    // let every result drain before going on
    in_tvalid <= 1'b0;
    wait_drained();

    repeat (160) send_item(pick_value(), 1'b1);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (80) @(negedge clk);

    $display("Checked %0d results (%0d with a larger permutation, %0d without),",
             sb.results_seen, sb.found_seen, sb.results_seen - sb.found_seen);
    $display("over corner values, random gaps, back-to-back traffic and a long stall.");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
